@@ sv/mono_framebuffer_scaler_rgb565_defines.svh @@
// Assertion macros shared by the scaler RTL.
`ifndef MONO_FRAMEBUFFER_SCALER_RGB565_DEFINES_SVH
`define MONO_FRAMEBUFFER_SCALER_RGB565_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSC_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("scaler check failed");

// The consequent must hold in the cycle after the antecedent.
`define MSC_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("scaler check failed");

`endif

@@ sv/msc_pkg.sv @@
`default_nettype none
package msc_pkg;

   // Payload widths of the channels.
   localparam int OP_W       = 1;
   localparam int FB_ADDR_W  = 15;
   localparam int FB_DATA_W  = 8;
   localparam int LCD_X_W    = 9;
   localparam int LCD_Y_W    = 8;
   localparam int PIXEL_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 9;

   // Default geometry.
   localparam int SRC_WIDTH_DEF    = 512;
   localparam int SRC_HEIGHT_DEF   = 342;
   localparam int PANEL_WIDTH_DEF  = 320;
   localparam int PANEL_HEIGHT_DEF = 240;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_WRITE  = 1'b0;
   localparam logic [OP_W-1:0] OP_RENDER = 1'b1;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_VIEW_LEFT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_VIEW_TOP    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_VIEW_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_VIEW_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FILTER_MODE = 3'd4;

   // Register reset values.
   localparam logic [8:0] VIEW_LEFT_RST   = 9'd0;
   localparam logic [7:0] VIEW_TOP_RST    = 8'd13;
   localparam logic [8:0] VIEW_WIDTH_RST  = 9'd320;
   localparam logic [7:0] VIEW_HEIGHT_RST = 8'd213;
   localparam logic       FILTER_MODE_RST = 1'b0;

   // Filter modes.
   localparam logic MODE_NEAREST = 1'b0;
   localparam logic MODE_AREA    = 1'b1;

   // Colors and gray scale.
   localparam logic [PIXEL_W-1:0] COLOR_WHITE = 16'hFFFF;
   localparam logic [PIXEL_W-1:0] COLOR_BLACK = 16'h0000;
   localparam logic [7:0]         GRAY_MAX    = 8'd255;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_SPAN,
      ST_ADDR,
      ST_TEST,
      ST_DONE
   } state_type;

   // Divisions that the sequencer runs on the shared divider.
   typedef enum logic [2:0] {
      JOB_X0,
      JOB_X1,
      JOB_Y0,
      JOB_Y1,
      JOB_GRAY
   } job_type;

   // Status of the divider.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   // Expand an 8-bit gray level to RGB565.
   function automatic logic [PIXEL_W-1:0] gray565(input logic [7:0] g);
      gray565 = {g[7:3], g[7:2], g[7:3]};
   endfunction

endpackage
`default_nettype wire

@@ sv/msc_if.sv @@
`default_nettype none
// Request channel: framebuffer writes and pixel renders.
interface msc_req_if;
   import msc_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [OP_W-1:0]      operation;
   logic [FB_ADDR_W-1:0] fb_address;
   logic [FB_DATA_W-1:0] fb_data;
   logic [LCD_X_W-1:0]   lcd_x;
   logic [LCD_Y_W-1:0]   lcd_y;
   modport source (output valid, operation, fb_address, fb_data, lcd_x, lcd_y,
                   input ready);
   modport sink (input valid, operation, fb_address, fb_data, lcd_x, lcd_y,
                 output ready);
endinterface

// Response channel: one color per render.
interface msc_rsp_if;
   import msc_pkg::*;
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel;
   logic               in_view;
   modport source (output valid, pixel, in_view, input ready);
   modport sink (input valid, pixel, in_view, output ready);
endinterface

// Register write channel.
interface msc_csr_if;
   import msc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ sv/msc_divider.sv @@
`default_nettype none
module msc_divider #(
   parameter int WIDTH = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [WIDTH-1:0]        dividend,
   input  wire logic [WIDTH-1:0]        divisor,
   output msc_pkg::div_status_type      status,
   output logic      [WIDTH-1:0]        quotient
);
   import msc_pkg::*;

   localparam int CNT_W = $clog2(WIDTH + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [WIDTH:0]   rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] dsr_ff, dsr_in;
   logic [WIDTH:0]   rem_shift;

   // One restoring step per cycle, quotient bits shift in from the right.
   assign rem_shift = {rem_ff[WIDTH-1:0], quo_ff[WIDTH-1]};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dsr_in   = dsr_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_W'(WIDTH);
         rem_in   = '0;
         quo_in   = dividend;
         dsr_in   = divisor;
      end else if (busy_ff) begin
         if (rem_shift >= {1'b0, dsr_ff}) begin
            rem_in = rem_shift - {1'b0, dsr_ff};
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = rem_shift;
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end
         count_in = count_ff - 1'b1;
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule
`default_nettype wire

@@ sv/msc_frame_store.sv @@
`default_nettype none
module msc_frame_store #(
   parameter int DEPTH  = 21888,
   parameter int ADDR_W = 15
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [7:0]        wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [7:0]        rd_data
);
   logic [7:0] mem [DEPTH];

   // Byte write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

@@ sv/mono_framebuffer_scaler_rgb565.sv @@
// Channel  | Direction | Handshake      | Payload
// req_ch   | in        | valid / ready  | operation, fb_address, fb_data, lcd_x, lcd_y
// rsp_ch   | out       | valid / ready  | pixel, in_view
// csr_ch   | in        | valid / ready  | index, data (always ready)
//
// A framebuffer write leaves the sequencer in its idle state, so the block stays ready.
// A render runs on one shared restoring divider of D bits, one quotient bit a cycle
// (D is 26 at the default geometry). Outside the viewport a render goes straight to
// the done state. Nearest: 2 divisions and a read of one source bit. Area: 5 divisions,
// the last for the gray level, and a read of every source bit of the span from the
// byte memory, each in an address state and a test state.
// Reset is synchronous and active high; the store content is undefined until written.
// A finished result waits in the output register; the sequencer holds in the done state while it is full and not taken.
`default_nettype none
`include "mono_framebuffer_scaler_rgb565_defines.svh"
module mono_framebuffer_scaler_rgb565 #(
   parameter int SRC_WIDTH    = msc_pkg::SRC_WIDTH_DEF,
   parameter int SRC_HEIGHT   = msc_pkg::SRC_HEIGHT_DEF,
   parameter int PANEL_WIDTH  = msc_pkg::PANEL_WIDTH_DEF,
   parameter int PANEL_HEIGHT = msc_pkg::PANEL_HEIGHT_DEF
) (
   input wire logic clock,
   input wire logic reset,
   msc_req_if.sink   req_ch,
   msc_rsp_if.source rsp_ch,
   msc_csr_if.sink   csr_ch
);
   import msc_pkg::*;

   localparam int BYTES_PER_LINE = SRC_WIDTH / 8;
   localparam int DEPTH     = BYTES_PER_LINE * SRC_HEIGHT;
   localparam int MEM_AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SRC_MAX   = (SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH : SRC_HEIGHT;
   localparam int CW        = $clog2(SRC_MAX + 1);
   localparam int IDX_W     = $clog2(DEPTH + BYTES_PER_LINE + 1);
   localparam int TOT_W     = $clog2(SRC_WIDTH * SRC_HEIGHT + 1);
   localparam int PROD_W    = LCD_X_W + CW + 1;
   localparam int DIV_W     = (TOT_W + 8 > PROD_W) ? TOT_W + 8 : PROD_W;

   // Configuration registers.
   logic [8:0] view_left_ff, view_width_ff;
   logic [7:0] view_top_ff, view_height_ff;
   logic       filter_mode_ff;

   // Sequencer and datapath registers.
   state_type          state_ff, state_in;
   job_type            job_ff, job_in;
   logic [LCD_X_W-1:0] x_ff, x_in;
   logic [LCD_Y_W-1:0] y_ff, y_in;
   logic [LCD_X_W-1:0] vx_ff, vx_in;
   logic [LCD_Y_W-1:0] vy_ff, vy_in;
   logic [CW-1:0]      x0_ff, x0_in, x1_ff, x1_in, y0_ff, y0_in, y1_ff, y1_in;
   logic [CW-1:0]      cx_ff, cx_in, cy_ff, cy_in;
   logic [TOT_W-1:0]   total_ff, total_in, black_ff, black_in;
   logic               in_range_ff, in_range_in;
   logic [2:0]         bit_sel_ff, bit_sel_in;
   logic [PIXEL_W-1:0] res_px_ff, res_px_in;
   logic               res_view_ff, res_view_in;
   logic [PIXEL_W-1:0] pixel_ff, pixel_in;
   logic               in_view_ff, in_view_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Shared divider and frame store connections.
   logic             div_start;
   logic [DIV_W-1:0] div_dividend, div_divisor, div_quotient;
   div_status_type   div_stat;
   logic [CW-1:0]    q_coord;
   logic             mem_wr_en, mem_rd_en;
   logic [7:0]       mem_rd_data;
   logic [IDX_W-1:0] rd_idx;

   // Control conditions used by the sequencer blocks.
   logic req_fire, in_box, bit_black, last_col, last_bit, out_free, area;
   logic [CW-1:0] x1_adj, y1_adj;

   assign area     = (filter_mode_ff == MODE_AREA);
   assign req_fire = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // Viewport test on the latched panel coordinate.
   assign in_box = (32'(x_ff) < PANEL_WIDTH) && (32'(y_ff) < PANEL_HEIGHT)
                   && (x_ff >= view_left_ff)
                   && ({1'b0, x_ff} < {1'b0, view_left_ff} + {1'b0, view_width_ff})
                   && (y_ff >= view_top_ff)
                   && ({1'b0, y_ff} < {1'b0, view_top_ff} + {1'b0, view_height_ff});

   // Operands for the current division.
   always_comb begin
      case (job_ff)
         JOB_X0: begin
            if (area) begin
               div_dividend = DIV_W'(vx_ff) * DIV_W'(SRC_WIDTH);
               div_divisor  = DIV_W'(view_width_ff);
            end else begin
               div_dividend = DIV_W'(vx_ff) * DIV_W'(SRC_WIDTH - 1);
               div_divisor  = DIV_W'(view_width_ff) - DIV_W'(1);
            end
         end
         JOB_X1: begin
            div_dividend = (DIV_W'(vx_ff) + DIV_W'(1)) * DIV_W'(SRC_WIDTH);
            div_divisor  = DIV_W'(view_width_ff);
         end
         JOB_Y0: begin
            if (area) begin
               div_dividend = DIV_W'(vy_ff) * DIV_W'(SRC_HEIGHT);
               div_divisor  = DIV_W'(view_height_ff);
            end else begin
               div_dividend = DIV_W'(vy_ff) * DIV_W'(SRC_HEIGHT - 1);
               div_divisor  = DIV_W'(view_height_ff) - DIV_W'(1);
            end
         end
         JOB_Y1: begin
            div_dividend = (DIV_W'(vy_ff) + DIV_W'(1)) * DIV_W'(SRC_HEIGHT);
            div_divisor  = DIV_W'(view_height_ff);
         end
         JOB_GRAY: begin
            div_dividend = (DIV_W'(black_ff) << 8) - DIV_W'(black_ff);
            div_divisor  = DIV_W'(total_ff);
         end
         default: begin
            div_dividend = '0;
            div_divisor  = '0;
         end
      endcase
   end

   // A view of one pixel divides by zero; its coordinate is zero.
   assign q_coord = (div_divisor == '0) ? '0 : CW'(div_quotient);

   // Span ends widened to at least one source pixel.
   assign x1_adj = (x1_ff <= x0_ff) ? x0_ff + 1'b1 : x1_ff;
   assign y1_adj = (y1_ff <= y0_ff) ? y0_ff + 1'b1 : y1_ff;

   // Byte index of the current source bit.
   assign rd_idx    = IDX_W'(cy_ff) * IDX_W'(BYTES_PER_LINE) + IDX_W'(cx_ff >> 3);
   assign bit_black = in_range_ff && mem_rd_data[3'd7 - bit_sel_ff];
   assign last_col  = (cx_ff + 1'b1 == x1_ff);
   assign last_bit  = last_col && (cy_ff + 1'b1 == y1_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_ch.operation == OP_RENDER) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK:     state_in = in_box ? ST_DIV_START : ST_DONE;
         ST_DIV_START: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_stat.done) begin
               case (job_ff)
                  JOB_Y0:   state_in = area ? ST_DIV_START : ST_ADDR;
                  JOB_Y1:   state_in = ST_SPAN;
                  JOB_GRAY: state_in = ST_DONE;
                  default:  state_in = ST_DIV_START;
               endcase
            end
         end
         ST_SPAN: state_in = ST_ADDR;
         ST_ADDR: state_in = ST_TEST;
         ST_TEST: begin
            if (!area) begin
               state_in = ST_DONE;
            end else if (last_bit) begin
               state_in = ST_DIV_START;
            end else begin
               state_in = ST_ADDR;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath updates and strobes.
   always_comb begin
      job_in       = job_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      y0_in        = y0_ff;
      y1_in        = y1_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      total_in     = total_ff;
      black_in     = black_ff;
      in_range_in  = in_range_ff;
      bit_sel_in   = bit_sel_ff;
      res_px_in    = res_px_ff;
      res_view_in  = res_view_ff;
      pixel_in     = pixel_ff;
      in_view_in   = in_view_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      div_start    = 1'b0;
      mem_wr_en    = 1'b0;
      mem_rd_en    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               x_in      = req_ch.lcd_x;
               y_in      = req_ch.lcd_y;
               mem_wr_en = (req_ch.operation == OP_WRITE)
                           && (32'(req_ch.fb_address) < DEPTH);
            end
         end
         ST_CHECK: begin
            vx_in       = x_ff - view_left_ff;
            vy_in       = y_ff - view_top_ff;
            job_in      = JOB_X0;
            res_px_in   = COLOR_WHITE;
            res_view_in = in_box;
         end
         ST_DIV_START: div_start = 1'b1;
         ST_DIV_WAIT: begin
            if (div_stat.done) begin
               case (job_ff)
                  JOB_X0: begin
                     x0_in  = q_coord;
                     job_in = area ? JOB_X1 : JOB_Y0;
                  end
                  JOB_X1: begin
                     x1_in  = q_coord;
                     job_in = JOB_Y0;
                  end
                  JOB_Y0: begin
                     y0_in  = q_coord;
                     job_in = JOB_Y1;
                     cx_in  = x0_ff;
                     cy_in  = q_coord;
                  end
                  JOB_Y1: y1_in = q_coord;
                  JOB_GRAY: res_px_in = gray565(GRAY_MAX - div_quotient[7:0]);
                  default: job_in = JOB_X0;
               endcase
            end
         end
         ST_SPAN: begin
            x1_in    = x1_adj;
            y1_in    = y1_adj;
            total_in = TOT_W'(x1_adj - x0_ff) * TOT_W'(y1_adj - y0_ff);
            cx_in    = x0_ff;
            cy_in    = y0_ff;
            black_in = '0;
         end
         ST_ADDR: begin
            mem_rd_en   = 1'b1;
            in_range_in = (32'(rd_idx) < DEPTH);
            bit_sel_in  = cx_ff[2:0];
         end
         ST_TEST: begin
            if (!area) begin
               res_px_in = bit_black ? COLOR_BLACK : COLOR_WHITE;
            end else begin
               black_in = black_ff + TOT_W'(bit_black);
               if (last_bit) begin
                  job_in = JOB_GRAY;
               end else if (last_col) begin
                  cx_in = x0_ff;
                  cy_in = cy_ff + 1'b1;
               end else begin
                  cx_in = cx_ff + 1'b1;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               pixel_in     = res_px_ff;
               in_view_in   = res_view_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: job_in = JOB_X0;
      endcase
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         job_ff         <= JOB_X0;
         rsp_valid_ff   <= 1'b0;
         view_left_ff   <= VIEW_LEFT_RST;
         view_top_ff    <= VIEW_TOP_RST;
         view_width_ff  <= VIEW_WIDTH_RST;
         view_height_ff <= VIEW_HEIGHT_RST;
         filter_mode_ff <= FILTER_MODE_RST;
      end else begin
         state_ff     <= state_in;
         job_ff       <= job_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_ch.valid) begin
            case (csr_ch.index)
               REG_VIEW_LEFT:   view_left_ff   <= csr_ch.data;
               REG_VIEW_TOP:    view_top_ff    <= csr_ch.data[7:0];
               REG_VIEW_WIDTH:  view_width_ff  <= csr_ch.data;
               REG_VIEW_HEIGHT: view_height_ff <= csr_ch.data[7:0];
               REG_FILTER_MODE: filter_mode_ff <= csr_ch.data[0];
               default: ;
            endcase
         end
      end
      x_ff        <= x_in;
      y_ff        <= y_in;
      vx_ff       <= vx_in;
      vy_ff       <= vy_in;
      x0_ff       <= x0_in;
      x1_ff       <= x1_in;
      y0_ff       <= y0_in;
      y1_ff       <= y1_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      total_ff    <= total_in;
      black_ff    <= black_in;
      in_range_ff <= in_range_in;
      bit_sel_ff  <= bit_sel_in;
      res_px_ff   <= res_px_in;
      res_view_ff <= res_view_in;
      pixel_ff    <= pixel_in;
      in_view_ff  <= in_view_in;
   end

   msc_divider #(
      .WIDTH (DIV_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .status   (div_stat),
      .quotient (div_quotient)
   );

   msc_frame_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (MEM_AW)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (MEM_AW'(req_ch.fb_address)),
      .wr_data (req_ch.fb_data),
      .rd_en   (mem_rd_en),
      .rd_addr (rd_idx[MEM_AW-1:0]),
      .rd_data (mem_rd_data)
   );

   // Channel outputs.
   assign req_ch.ready   = (state_ff == ST_IDLE);
   assign csr_ch.ready   = 1'b1;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.pixel   = pixel_ff;
   assign rsp_ch.in_view = in_view_ff;

   // Border pixels are always white.
   `MSC_ASSERT_NOW(a_border_white, clock, reset, rsp_ch.valid && !rsp_ch.in_view,
                   rsp_ch.pixel == COLOR_WHITE)
   // The divider is never restarted while it runs.
   `MSC_ASSERT_NOW(a_div_idle_start, clock, reset, div_start, !div_stat.busy)
   // The scan stays within the widened span.
   `MSC_ASSERT_NOW(a_scan_in_span, clock, reset, state_ff == ST_TEST && area,
                   cx_ff < x1_ff && cy_ff < y1_ff && cx_ff >= x0_ff)
   // A render always reaches the output register after the done state frees it.
   `MSC_ASSERT_NEXT(a_done_loads, clock, reset, state_ff == ST_DONE && out_free,
                    rsp_ch.valid && state_ff == ST_IDLE)

endmodule
`default_nettype wire

@@ test/tb_mono_framebuffer_scaler_rgb565.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tb_mono_framebuffer_scaler_rgb565;
   import msc_pkg::*;

   localparam int BYTES_PER_LINE = SRC_WIDTH_DEF / 8;
   localparam int STORE_BYTES    = BYTES_PER_LINE * SRC_HEIGHT_DEF;

   typedef struct {
      logic [OP_W-1:0]      operation;
      logic [FB_ADDR_W-1:0] fb_address;
      logic [FB_DATA_W-1:0] fb_data;
      logic [LCD_X_W-1:0]   lcd_x;
      logic [LCD_Y_W-1:0]   lcd_y;
   } request_type;

   typedef struct {
      logic [PIXEL_W-1:0] pixel;
      logic               in_view;
   } color_type;

   logic clock;
   logic reset;

   msc_req_if req_if ();
   msc_rsp_if rsp_if ();
   msc_csr_if csr_if ();

   mono_framebuffer_scaler_rgb565 DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // Mirror of the frame store and the viewport registers.
   logic [7:0]  fb_mirror [STORE_BYTES];
   logic [8:0]  mir_left;
   logic [7:0]  mir_top;
   logic [8:0]  mir_width;
   logic [7:0]  mir_height;
   logic        mir_mode;

   // Bytes that some queued write already covers.
   bit          fb_planned [STORE_BYTES];

   request_type pending_requests [$];
   color_type   expected_colors [$];
   logic        req_taken;
   logic        no_gaps;
   int          hold_trigger;
   int          hold_seen;
   int          hold_left;
   int          mismatches;
   int          failures;

   // Clock.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // A run that hangs is a failure.
   initial begin
      #40ms;
      $display("FAIL");
      $finish;
   end

   function automatic bit source_black(int unsigned sx, int unsigned sy);
      int unsigned idx;
      idx = sy * BYTES_PER_LINE + (sx >> 3);
      if (idx >= STORE_BYTES) return 1'b0;
      return fb_mirror[idx][7 - (sx & 7)];
   endfunction

   function automatic int unsigned nearest_pos(int unsigned pos, int unsigned src,
                                               int unsigned view);
      if (view <= 1) return 0;
      return (pos * (src - 1)) / (view - 1);
   endfunction

   // Expected color of one panel pixel under the current viewport.
   function automatic color_type render_color(logic [LCD_X_W-1:0] x, logic [LCD_Y_W-1:0] y);
      color_type c;
      int unsigned vx, vy, x0, x1, y0, y1, black, total, g;
      c.pixel   = COLOR_WHITE;
      c.in_view = 1'b0;
      if (x < PANEL_WIDTH_DEF && y < PANEL_HEIGHT_DEF &&
          x >= mir_left && int'(x) < int'(mir_left) + int'(mir_width) &&
          y >= mir_top && int'(y) < int'(mir_top) + int'(mir_height)) begin
         vx = 32'(x) - 32'(mir_left);
         vy = 32'(y) - 32'(mir_top);
         c.in_view = 1'b1;
         if (mir_mode == MODE_NEAREST) begin
            c.pixel = source_black(nearest_pos(vx, SRC_WIDTH_DEF, 32'(mir_width)),
                                   nearest_pos(vy, SRC_HEIGHT_DEF, 32'(mir_height)))
                      ? COLOR_BLACK : COLOR_WHITE;
         end else begin
            x0 = (vx * SRC_WIDTH_DEF) / mir_width;
            x1 = ((vx + 1) * SRC_WIDTH_DEF) / mir_width;
            if (x1 <= x0) x1 = x0 + 1;
            y0 = (vy * SRC_HEIGHT_DEF) / mir_height;
            y1 = ((vy + 1) * SRC_HEIGHT_DEF) / mir_height;
            if (y1 <= y0) y1 = y0 + 1;
            total = (x1 - x0) * (y1 - y0);
            black = 0;
            for (int unsigned j = y0; j < y1; j++)
               for (int unsigned i = x0; i < x1; i++)
                  if (source_black(i, j)) black++;
            g = 255 - (black * 255) / total;
            c.pixel = {g[7:3], g[7:2], g[7:3]};
         end
      end
      return c;
   endfunction

   // Request driver: new payloads go out at the falling edge.
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid      <= 1'b0;
         req_if.operation  <= OP_WRITE;
         req_if.fb_address <= '0;
         req_if.fb_data    <= '0;
         req_if.lcd_x      <= '0;
         req_if.lcd_y      <= '0;
      end else if (!req_if.valid || req_taken) begin
         if (pending_requests.size() > 0 && (no_gaps || $urandom_range(0, 99) >= 25)) begin
            req_if.valid      <= 1'b1;
            req_if.operation  <= pending_requests[0].operation;
            req_if.fb_address <= pending_requests[0].fb_address;
            req_if.fb_data    <= pending_requests[0].fb_data;
            req_if.lcd_x      <= pending_requests[0].lcd_x;
            req_if.lcd_y      <= pending_requests[0].lcd_y;
            void'(pending_requests.pop_front());
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Response ready: random stalls, plus one long hold-off on request.
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         hold_seen    <= 0;
         hold_left    <= 0;
      end else if (hold_trigger != hold_seen) begin
         hold_seen    <= hold_trigger;
         hold_left    <= 400;
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left    <= hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= no_gaps || $urandom_range(0, 99) >= 25;
      end
   end

   // Monitor: mirror updates, prediction and response checking.
   always @(posedge clock) begin
      color_type want;
      req_taken <= !reset && req_if.valid && req_if.ready;
      if (reset) begin
         mir_left   = VIEW_LEFT_RST;
         mir_top    = VIEW_TOP_RST;
         mir_width  = VIEW_WIDTH_RST;
         mir_height = VIEW_HEIGHT_RST;
         mir_mode   = FILTER_MODE_RST;
         mismatches = 0;
         failures   = 0;
      end else begin
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.index)
               REG_VIEW_LEFT:   mir_left   = csr_if.data[8:0];
               REG_VIEW_TOP:    mir_top    = csr_if.data[7:0];
               REG_VIEW_WIDTH:  mir_width  = csr_if.data[8:0];
               REG_VIEW_HEIGHT: mir_height = csr_if.data[7:0];
               REG_FILTER_MODE: mir_mode   = csr_if.data[0];
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready) begin
            if (req_if.operation == OP_WRITE) begin
               if (req_if.fb_address < STORE_BYTES)
                  fb_mirror[req_if.fb_address] = req_if.fb_data;
            end else begin
               expected_colors.push_back(render_color(req_if.lcd_x, req_if.lcd_y));
            end
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_colors.size() == 0) begin
               failures++;
               if (mismatches < 10)
                  $display("Unexpected response pixel=%h in_view=%b",
                           rsp_if.pixel, rsp_if.in_view);
               mismatches++;
            end else begin
               want = expected_colors.pop_front();
               if (rsp_if.pixel !== want.pixel || rsp_if.in_view !== want.in_view) begin
                  failures++;
                  if (mismatches < 10)
                     $display("Mismatch: expected pixel=%h in_view=%b, got pixel=%h in_view=%b",
                              want.pixel, want.in_view, rsp_if.pixel, rsp_if.in_view);
                  mismatches++;
               end
            end
         end
      end
   end

   task automatic add_write(int unsigned addr, int unsigned data);
      request_type r;
      r.operation  = OP_WRITE;
      r.fb_address = addr[FB_ADDR_W-1:0];
      r.fb_data    = data[7:0];
      r.lcd_x      = LCD_X_W'($urandom);
      r.lcd_y      = LCD_Y_W'($urandom);
      if (addr < STORE_BYTES) fb_planned[addr] = 1'b1;
      pending_requests.push_back(r);
   endtask

   // Queue a write for every source byte that a render of this pixel reads
   // and that no earlier request has written yet.
   task automatic cover_footprint(int unsigned x, int unsigned y);
      int unsigned px, py, vx, vy, x0, x1, y0, y1, addr;
      px = x & 32'h1FF;
      py = y & 32'hFF;
      if (px < PANEL_WIDTH_DEF && py < PANEL_HEIGHT_DEF &&
          px >= mir_left && px < 32'(mir_left) + 32'(mir_width) &&
          py >= mir_top && py < 32'(mir_top) + 32'(mir_height)) begin
         vx = px - 32'(mir_left);
         vy = py - 32'(mir_top);
         if (mir_mode == MODE_NEAREST) begin
            x0 = nearest_pos(vx, SRC_WIDTH_DEF, 32'(mir_width));
            x1 = x0 + 1;
            y0 = nearest_pos(vy, SRC_HEIGHT_DEF, 32'(mir_height));
            y1 = y0 + 1;
         end else begin
            x0 = (vx * SRC_WIDTH_DEF) / mir_width;
            x1 = ((vx + 1) * SRC_WIDTH_DEF) / mir_width;
            if (x1 <= x0) x1 = x0 + 1;
            y0 = (vy * SRC_HEIGHT_DEF) / mir_height;
            y1 = ((vy + 1) * SRC_HEIGHT_DEF) / mir_height;
            if (y1 <= y0) y1 = y0 + 1;
         end
         for (int unsigned j = y0; j < y1; j++)
            for (int unsigned b = x0 >> 3; b <= ((x1 - 1) >> 3); b++) begin
               addr = j * BYTES_PER_LINE + b;
               if (addr < STORE_BYTES && !fb_planned[addr]) add_write(addr, $urandom);
            end
      end
   endtask

   task automatic add_render(int unsigned x, int unsigned y);
      request_type r;
      cover_footprint(x, y);
      r.operation  = OP_RENDER;
      r.fb_address = FB_ADDR_W'($urandom);
      r.fb_data    = FB_DATA_W'($urandom);
      r.lcd_x      = x[LCD_X_W-1:0];
      r.lcd_y      = y[LCD_Y_W-1:0];
      pending_requests.push_back(r);
   endtask

   // Wait until every request is taken and every response has come back.
   task automatic drain();
      while (pending_requests.size() > 0 || req_if.valid || expected_colors.size() > 0)
         @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int unsigned data);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data[CSR_DATA_W-1:0];
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic set_view(int unsigned l, int unsigned t, int unsigned w, int unsigned h,
                           logic m);
      drain();
      write_reg(REG_VIEW_LEFT, l);
      write_reg(REG_VIEW_TOP, t);
      write_reg(REG_VIEW_WIDTH, w);
      write_reg(REG_VIEW_HEIGHT, h);
      write_reg(REG_FILTER_MODE, m);
   endtask

   // Mostly renders inside the viewport, some border and off-panel pixels, some writes.
   // The count includes the writes that cover what the renders read.
   task automatic add_random(int n);
      int unsigned sel, x, y;
      int queued, depth0;
      queued = 0;
      while (queued < n) begin
         depth0 = pending_requests.size();
         sel = $urandom_range(0, 99);
         if (sel < 20) begin
            add_write($urandom_range(0, STORE_BYTES - 1), $urandom);
         end else if (sel < 24) begin
            add_write($urandom_range(STORE_BYTES, 32767), $urandom);
         end else if (sel < 36 || mir_width == 0 || mir_height == 0) begin
            add_render($urandom_range(0, 511), $urandom_range(0, 255));
         end else begin
            x = mir_left + $urandom_range(0, mir_width - 1);
            y = mir_top + $urandom_range(0, mir_height - 1);
            add_render(x, y);
         end
         queued += pending_requests.size() - depth0;
      end
   endtask

   // Stimulus.
   initial begin
      reset        = 1'b1;
      csr_if.valid = 1'b0;
      csr_if.index = REG_VIEW_LEFT;
      csr_if.data  = '0;
      no_gaps      = 1'b0;
      hold_trigger = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Each render is preceded by writes of the bytes it reads, so no render
      // ever reads an unwritten byte.
      add_write(0, 8'hFF);
      add_write(STORE_BYTES - 1, 8'h00);
      add_write(STORE_BYTES, 8'hAA);
      add_write(32767, 8'h55);

      // Reset viewport: corners, border and off-panel pixels.
      add_render(0, 13);
      add_render(319, 225);
      add_render(0, 12);
      add_render(319, 226);
      add_render(511, 255);
      add_render(320, 100);
      add_render(100, 240);
      add_random(60);

      // Full panel, area mode; this phase runs with no gaps on either side.
      set_view(0, 0, 320, 240, MODE_AREA);
      no_gaps = 1'b1;
      add_render(0, 0);
      add_render(319, 239);
      add_random(80);
      drain();
      no_gaps = 1'b0;

      // Single pixel viewport at the far corner.
      set_view(319, 239, 1, 1, MODE_NEAREST);
      add_render(319, 239);
      add_render(318, 239);
      add_random(20);

      // Zero view size.
      set_view(0, 0, 0, 0, MODE_NEAREST);
      add_render(0, 0);
      add_random(20);

      // Viewport running past the panel edge, with a long response hold-off.
      set_view(200, 100, 320, 240, MODE_NEAREST);
      hold_trigger = 1;
      add_render(200, 100);
      add_render(319, 239);
      add_random(100);

      // Small area views, extremes of the register ranges.
      set_view(150, 100, 16, 16, MODE_AREA);
      add_random(15);
      set_view(511, 255, 320, 240, MODE_NEAREST);
      add_random(15);

      // Random viewports.
      for (int p = 0; p < 10; p++) begin
         set_view($urandom_range(0, 319), $urandom_range(0, 239),
                  $urandom_range(64, 320), $urandom_range(48, 240),
                  1'($urandom_range(0, 1)));
         add_random(70);
      end

      drain();
      repeat (200) @(posedge clock);
      if (failures == 0 && expected_colors.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire

@@ files.f @@
+incdir+sv
sv/msc_pkg.sv
sv/msc_if.sv
sv/msc_divider.sv
sv/msc_frame_store.sv
sv/mono_framebuffer_scaler_rgb565.sv
test/tb_mono_framebuffer_scaler_rgb565.sv
